@@ rtl/sks_pkg.sv @@
// shared constants, types and helpers of the sorted key set engine
`timescale 1ns / 1ps

package sks_pkg;

  // pool geometry
  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int PTR_W      = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W      = 32;

  localparam logic [PTR_W-1:0] END_MARK = PTR_W'(SLOT_COUNT);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SLOT_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [KEY_W-1:0] KEY_MAX  = {KEY_W{1'b1}};

  // request codes
  typedef enum logic [1:0] {
    REQ_INIT     = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_CONTAINS = 2'd3
  } req_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_ADD_LINK,
    ST_ADD_SET,
    ST_REM_SET,
    ST_RESP
  } state_e;

  // access request to the key and link memories
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             link_we;
    logic             key_we;
    logic [IDX_W-1:0] waddr;
    logic [PTR_W-1:0] link_wdata;
    logic [KEY_W-1:0] key_wdata;
  } sks_mem_req_t;

  // any link at or beyond the pool size means end of chain
  function automatic logic [PTR_W-1:0] ptr_clamp(input logic [PTR_W-1:0] ptr);
    ptr_clamp = (ptr >= END_MARK) ? END_MARK : ptr;
  endfunction

endpackage

@@ rtl/sorted_key_set_engine.sv @@
// sorted key set engine: linked list of keys in a slot pool, with free list
// contains and a failed add or remove go from the walk to the decision and the result;
// remove adds a set step, add a link step and a set step; list nodes are read one per
// cycle through the key compare and registered read; init relinks one slot per cycle
// throughput: one word at a time; the next word is taken once the result is out
// reset: a relink pass over all 256 slots runs first with in_stall_o high, list empty
`timescale 1ns / 1ps

module sorted_key_set_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_req_type_i,
  input  logic [sks_pkg::KEY_W-1:0] in_key_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      out_ok_o
);

  sks_pkg::sks_mem_req_t     mem_req;
  logic [sks_pkg::KEY_W-1:0] key_rdata;
  logic [sks_pkg::PTR_W-1:0] link_rdata;
  logic                      res_valid;
  logic                      res_ok;
  logic                      res_take;
  logic                      out_valid_q, out_valid_d;
  logic                      out_ok_q, out_ok_d;

  // sequencer
  sks_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .in_key_i      (in_key_i),
    .res_valid_o   (res_valid),
    .res_ok_o      (res_ok),
    .res_take_i    (res_take),
    .mem_req_o     (mem_req),
    .key_rdata_i   (key_rdata),
    .link_rdata_i  (link_rdata)
  );

  // slot keys
  sks_ram #(
    .WIDTH (sks_pkg::KEY_W),
    .DEPTH (sks_pkg::SLOT_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.key_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.key_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (key_rdata)
  );

  // slot links
  sks_ram #(
    .WIDTH (sks_pkg::PTR_W),
    .DEPTH (sks_pkg::SLOT_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.link_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.link_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (link_rdata)
  );

  // output register
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_ok_d    = out_ok_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_ok_d    = res_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q <= out_ok_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;

  // an accepted word keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in progress");

  // a key is only written together with the link of the same slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.key_we |-> mem_req.link_we)
    else $error("key written without its link");

  // no memory read in a cycle that rewrites a link
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.link_we))
    else $error("link memory read and write in the same cycle");

  // a result is only offered after the sequencer finished a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("result offered while input is open");

endmodule

@@ rtl/sks_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sks_seq.sv @@
// list walk sequencer with the shared key compare and pointer registers
`timescale 1ns / 1ps

module sks_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  in_req_type_i,
  input  logic [sks_pkg::KEY_W-1:0]   in_key_i,
  output logic                        res_valid_o,
  output logic                        res_ok_o,
  input  logic                        res_take_i,
  output sks_pkg::sks_mem_req_t       mem_req_o,
  input  logic [sks_pkg::KEY_W-1:0]   key_rdata_i,
  input  logic [sks_pkg::PTR_W-1:0]   link_rdata_i
);

  sks_pkg::state_e state_q, state_d;
  sks_pkg::req_e   req_q, req_d, in_req;

  logic [sks_pkg::KEY_W-1:0] key_q, key_d;
  logic [sks_pkg::KEY_W-1:0] cur_key_q, cur_key_d;
  logic [sks_pkg::PTR_W-1:0] cur_q, cur_d;
  logic [sks_pkg::PTR_W-1:0] pred_q, pred_d;
  logic [sks_pkg::PTR_W-1:0] steps_q, steps_d;
  logic [sks_pkg::PTR_W-1:0] cur_link_q, cur_link_d;
  logic [sks_pkg::PTR_W-1:0] free_head_q, free_head_d;
  logic [sks_pkg::PTR_W-1:0] list_first_q, list_first_d;
  logic [sks_pkg::IDX_W-1:0] new_q, new_d;
  logic [sks_pkg::IDX_W-1:0] sweep_idx_q, sweep_idx_d;
  logic                      sweep_resp_q, sweep_resp_d;
  logic                      res_ok_q, res_ok_d;

  logic                      in_accept;
  logic                      walk_adv;
  logic [sks_pkg::PTR_W-1:0] walk_next;
  logic                      cur_end;
  logic                      hit;
  logic                      add_fail;
  logic [sks_pkg::PTR_W-1:0] set_target;

  assign in_req    = sks_pkg::req_e'(in_req_type_i);
  assign in_accept = in_valid_i && (state_q == sks_pkg::ST_IDLE);

  // shared compare unit: advance while the node key is below the search key and fewer than 256 steps were taken
  assign walk_adv  = (key_rdata_i < key_q) && (steps_q < sks_pkg::END_MARK);
  assign walk_next = sks_pkg::ptr_clamp(link_rdata_i);

  // decision terms on the node where the walk stopped
  assign cur_end  = (cur_q == sks_pkg::END_MARK);
  assign hit      = !cur_end && (cur_key_q == key_q);
  assign add_fail = hit || (cur_end && (key_q == sks_pkg::KEY_MAX)) ||
                    (free_head_q == sks_pkg::END_MARK);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sks_pkg::ST_SWEEP: begin
        if (sweep_idx_q == sks_pkg::LAST_IDX) begin
          state_d = sweep_resp_q ? sks_pkg::ST_RESP : sks_pkg::ST_IDLE;
        end
      end
      sks_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req == sks_pkg::REQ_INIT) begin
            state_d = sks_pkg::ST_SWEEP;
          end else if (sks_pkg::ptr_clamp(list_first_q) == sks_pkg::END_MARK) begin
            state_d = sks_pkg::ST_DECIDE;
          end else begin
            state_d = sks_pkg::ST_WALK;
          end
        end
      end
      sks_pkg::ST_WALK: begin
        if (!(walk_adv && (walk_next != sks_pkg::END_MARK))) begin
          state_d = sks_pkg::ST_DECIDE;
        end
      end
      sks_pkg::ST_DECIDE: begin
        if ((req_q == sks_pkg::REQ_ADD) && !add_fail) begin
          state_d = sks_pkg::ST_ADD_LINK;
        end else if ((req_q == sks_pkg::REQ_REMOVE) && hit) begin
          state_d = sks_pkg::ST_REM_SET;
        end else begin
          state_d = sks_pkg::ST_RESP;
        end
      end
      sks_pkg::ST_ADD_LINK: state_d = sks_pkg::ST_ADD_SET;
      sks_pkg::ST_ADD_SET:  state_d = sks_pkg::ST_RESP;
      sks_pkg::ST_REM_SET:  state_d = sks_pkg::ST_RESP;
      sks_pkg::ST_RESP: begin
        if (res_take_i) begin
          state_d = sks_pkg::ST_IDLE;
        end
      end
      default: state_d = sks_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != sks_pkg::ST_IDLE);
    res_valid_o = (state_q == sks_pkg::ST_RESP);
    res_ok_o    = res_ok_q;
  end

  // pointer for the predecessor update of add and remove
  assign set_target = (state_q == sks_pkg::ST_ADD_SET) ? sks_pkg::PTR_W'(new_q) :
                                                         sks_pkg::ptr_clamp(cur_link_q);

  // datapath registers and memory accesses
  always_comb begin
    req_d        = req_q;
    key_d        = key_q;
    cur_key_d    = cur_key_q;
    cur_d        = cur_q;
    pred_d       = pred_q;
    steps_d      = steps_q;
    cur_link_d   = cur_link_q;
    free_head_d  = free_head_q;
    list_first_d = list_first_q;
    new_d        = new_q;
    sweep_idx_d  = sweep_idx_q;
    sweep_resp_d = sweep_resp_q;
    res_ok_d     = res_ok_q;
    mem_req_o    = '0;

    case (state_q)
      // relink one slot a cycle as a free chain
      sks_pkg::ST_SWEEP: begin
        mem_req_o.link_we    = 1'b1;
        mem_req_o.waddr      = sweep_idx_q;
        mem_req_o.link_wdata = (sweep_idx_q == '0) ? sks_pkg::END_MARK :
                               sks_pkg::PTR_W'(sweep_idx_q) - sks_pkg::PTR_W'(1);
        sweep_idx_d          = sweep_idx_q + sks_pkg::IDX_W'(1);
        if (sweep_idx_q == sks_pkg::LAST_IDX) begin
          free_head_d  = sks_pkg::LAST_PTR;
          list_first_d = sks_pkg::END_MARK;
          res_ok_d     = 1'b0;
        end
      end
      // take a word and start the walk at the list head, or the relink pass for init
      sks_pkg::ST_IDLE: begin
        if (in_accept) begin
          req_d   = in_req;
          key_d   = in_key_i;
          pred_d  = sks_pkg::END_MARK;
          steps_d = '0;
          cur_d   = sks_pkg::ptr_clamp(list_first_q);
          if (in_req == sks_pkg::REQ_INIT) begin
            sweep_idx_d  = '0;
            sweep_resp_d = 1'b1;
          end else if (sks_pkg::ptr_clamp(list_first_q) != sks_pkg::END_MARK) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = list_first_q[sks_pkg::IDX_W-1:0];
          end
        end
      end
      // one node per cycle
      sks_pkg::ST_WALK: begin
        if (walk_adv) begin
          pred_d  = cur_q;
          cur_d   = walk_next;
          steps_d = steps_q + sks_pkg::PTR_W'(1);
          if (walk_next != sks_pkg::END_MARK) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = walk_next[sks_pkg::IDX_W-1:0];
          end
        end else begin
          cur_key_d  = key_rdata_i;
          cur_link_d = link_rdata_i;
        end
      end
      // settle the result; for a hit remove or a successful add, start the list update
      sks_pkg::ST_DECIDE: begin
        case (req_q)
          sks_pkg::REQ_CONTAINS: begin
            res_ok_d = (key_q == '0) || hit || (cur_end && (key_q == sks_pkg::KEY_MAX));
          end
          sks_pkg::REQ_ADD: begin
            res_ok_d = !add_fail;
            new_d    = free_head_q[sks_pkg::IDX_W-1:0];
            if (!add_fail) begin
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = free_head_q[sks_pkg::IDX_W-1:0];
            end
          end
          sks_pkg::REQ_REMOVE: begin
            res_ok_d = hit;
            if (hit) begin
              mem_req_o.link_we    = 1'b1;
              mem_req_o.waddr      = cur_q[sks_pkg::IDX_W-1:0];
              mem_req_o.link_wdata = free_head_q;
              free_head_d          = cur_q;
            end
          end
          default: res_ok_d = 1'b0;
        endcase
      end
      // pop the free slot and fill it
      sks_pkg::ST_ADD_LINK: begin
        free_head_d          = walk_next;
        mem_req_o.key_we     = 1'b1;
        mem_req_o.link_we    = 1'b1;
        mem_req_o.waddr      = new_q;
        mem_req_o.key_wdata  = key_q;
        mem_req_o.link_wdata = cur_q;
      end
      // point the predecessor (or the list head) past the change
      sks_pkg::ST_ADD_SET, sks_pkg::ST_REM_SET: begin
        if (pred_q == sks_pkg::END_MARK) begin
          list_first_d = set_target;
        end else begin
          mem_req_o.link_we    = 1'b1;
          mem_req_o.waddr      = pred_q[sks_pkg::IDX_W-1:0];
          mem_req_o.link_wdata = set_target;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sks_pkg::ST_SWEEP;
      sweep_idx_q  <= '0;
      sweep_resp_q <= 1'b0;
      free_head_q  <= sks_pkg::LAST_PTR;
      list_first_q <= sks_pkg::END_MARK;
    end else begin
      state_q      <= state_d;
      sweep_idx_q  <= sweep_idx_d;
      sweep_resp_q <= sweep_resp_d;
      free_head_q  <= free_head_d;
      list_first_q <= list_first_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    cur_key_q  <= cur_key_d;
    cur_q      <= cur_d;
    pred_q     <= pred_d;
    steps_q    <= steps_d;
    cur_link_q <= cur_link_d;
    new_q      <= new_d;
    res_ok_q   <= res_ok_d;
  end

endmodule
